>>> rtl/core/scba_pkg.sv
// Shared types, codes and constants of the size-class bitmap allocator.
// Used by the register block, the request decoder and the top level.
package scba_pkg;

  localparam int unsigned MAX_ORDER_DEF = 4;
  localparam int unsigned HEAPS_DEF     = 8;

  localparam logic [4:0] SHIFT_MIN = 5'd8;
  localparam logic [4:0] SHIFT_MAX = 5'd20;
  localparam logic [4:0] SHIFT_RST = 5'd16;
  localparam logic [2:0] ORDER_RST = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    REG_PAGE_SHIFT = 1'b0,
    REG_MAX_ORDER  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] page_shift;
    logic [2:0] max_order;
  } cfg_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] order;
    logic [3:0] per_shift;
    logic [4:0] blk_shift;
    logic [4:0] heap_shift;
  } req_info_t;

  function automatic logic [3:0] bit_len8(input logic [7:0] v);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        len = 4'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

>>> rtl/core/scba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module scba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 40,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/scba_regs.sv
// APB-style configuration registers: page shift and largest size class.
// Depends on scba_pkg.
module scba_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output scba_pkg::cfg_t cfg
);
  import scba_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_shift <= SHIFT_RST;
      cfg.max_order  <= ORDER_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAGE_SHIFT: cfg.page_shift <= pwdata[4:0];
        REG_MAX_ORDER:  cfg.max_order  <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAGE_SHIFT: prdata = {27'd0, cfg.page_shift};
      REG_MAX_ORDER:  prdata = {29'd0, cfg.max_order};
    endcase
  end

endmodule

>>> rtl/core/scba_decode.sv
// Request decoder: clamps the geometry, checks the size and finds the size class.
// Depends on scba_pkg.
module scba_decode #(
  parameter int unsigned MAX_ORDER = scba_pkg::MAX_ORDER_DEF
) (
  input  logic               action,
  input  logic [31:0]        request_size,
  input  logic [31:0]        free_bytes,
  input  scba_pkg::cfg_t     cfg,
  output scba_pkg::req_info_t info
);
  import scba_pkg::*;

  logic [4:0]  shift;
  logic [3:0]  mo;
  logic [4:0]  hs;
  logic [31:0] size;
  logic [31:0] sm1;
  logic [31:0] pm1;
  logic [3:0]  ord_raw;
  logic [3:0]  ord;

  always_comb begin
    shift = cfg.page_shift;
    if (shift < SHIFT_MIN) begin
      shift = SHIFT_MIN;
    end else if (shift > SHIFT_MAX) begin
      shift = SHIFT_MAX;
    end
    if ({1'b0, cfg.max_order} > 4'(MAX_ORDER)) begin
      mo = 4'(MAX_ORDER);
    end else begin
      mo = {1'b0, cfg.max_order};
    end
    hs      = shift + 5'(mo);
    size    = (action == ACT_FREE) ? free_bytes : request_size;
    sm1     = size - 32'd1;
    pm1     = sm1 >> shift;
    ord_raw = bit_len8(pm1[7:0]);
    ord     = (ord_raw > mo) ? mo : ord_raw;

    info.bad        = (size == 32'd0) || ((sm1 >> hs) != 32'd0);
    info.order      = ord;
    info.per_shift  = mo - ord;
    info.blk_shift  = shift + 5'(ord);
    info.heap_shift = hs;
  end

endmodule

>>> rtl/core/size_class_bitmap_allocator_top.sv
// Top level of the size-class bitmap allocator: control sequencer, heap counts
// and the busy bitmap memory. Depends on scba_pkg, scba_regs, scba_decode, scba_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  request   | start / busy         | action, request_size, free_addr, free_bytes
//  result    | done (one cycle)     | status, block_addr, block_bytes
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// An allocate request reads one bitmap word per cycle, one per open heap of its
// class, until it finds a free block or has read them all.
// A free request reads one bitmap word and writes it back; a rejected request
// writes nothing to the single bitmap memory.
// After reset the bitmap is cleared one word a cycle, all (MAX_ORDER+1)*HEAPS words,
// with busy high. Results cannot be held off by the receiver.
module size_class_bitmap_allocator_top #(
  parameter int unsigned MAX_ORDER = scba_pkg::MAX_ORDER_DEF,
  parameter int unsigned HEAPS     = scba_pkg::HEAPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] request_size,
  input  logic [31:0] free_addr,
  input  logic [31:0] free_bytes,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] block_addr,
  output logic [31:0] block_bytes
);
  import scba_pkg::*;

  localparam int unsigned WORDW = 1 << MAX_ORDER;
  localparam int unsigned DEPTH = (MAX_ORDER + 1) * HEAPS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HW    = $clog2(HEAPS + 1);
  localparam int unsigned HIW   = (HEAPS > 1) ? $clog2(HEAPS) : 1;
  localparam int unsigned OW    = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int unsigned JW    = (MAX_ORDER > 0) ? MAX_ORDER : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_FREE_WB
  } state_t;

  state_t     state, state_next;
  cfg_t       cfg;
  req_info_t  info_in, info_q;
  logic       act_q;
  logic [31:0] addr_q;

  logic [HW-1:0]  heaps_open [MAX_ORDER + 1];
  logic [HIW-1:0] heap, heap_next;
  logic [JW-1:0]  pidx, pidx_next;
  logic [AW-1:0]  clr_cnt, clr_next;

  logic        done_next;
  status_t     status_next;
  logic [31:0] baddr_next;
  logic [31:0] bbytes_next;

  logic          open_we;
  logic [HW-1:0] open_wval;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WORDW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [WORDW-1:0] mem_rdata;

  logic [OW-1:0]    ord;
  logic [HW-1:0]    open_cur;
  logic [AW-1:0]    row_base;
  logic [31:0]      hidx32;
  logic [31:0]      pidx32;
  logic [WORDW-1:0] valid_bits;
  logic [WORDW-1:0] free_bits;
  logic [JW-1:0]    first_free;
  logic [31:0]      blk_bytes;

  scba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scba_decode #(.MAX_ORDER(MAX_ORDER)) u_decode (
    .action       (action),
    .request_size (request_size),
    .free_bytes   (free_bytes),
    .cfg          (cfg),
    .info         (info_in)
  );

  scba_ram #(.WIDTH(WORDW), .DEPTH(DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign ord       = info_q.order[OW-1:0];
  assign open_cur  = heaps_open[ord];
  assign row_base  = AW'(ord) * AW'(HEAPS);
  assign hidx32    = addr_q >> info_q.heap_shift;
  assign pidx32    = (addr_q >> info_q.blk_shift) & ((32'd1 << info_q.per_shift) - 32'd1);
  assign blk_bytes = 32'd1 << info_q.blk_shift;
  assign free_bits = ~mem_rdata & valid_bits;

  always_comb begin
    for (int i = 0; i < WORDW; i++) begin
      valid_bits[i] = ((32'(i) >> info_q.per_shift) == 32'd0);
    end
  end

  always_comb begin
    first_free = '0;
    for (int i = WORDW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        first_free = JW'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    heap_next   = heap;
    pidx_next   = pidx;
    clr_next    = clr_cnt;
    done_next   = 1'b0;
    status_next = ST_OK;
    baddr_next  = 32'd0;
    bbytes_next = 32'd0;
    open_we     = 1'b0;
    open_wval   = open_cur;
    mem_we      = 1'b0;
    mem_waddr   = row_base + AW'(heap);
    mem_wdata   = '0;
    mem_raddr   = row_base + AW'(heap);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        clr_next  = clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (info_q.bad) begin
          done_next   = 1'b1;
          status_next = ST_BAD;
          state_next  = S_IDLE;
        end else if (act_q == ACT_ALLOC) begin
          heap_next  = '0;
          mem_raddr  = row_base;
          state_next = S_SCAN;
        end else if (hidx32 >= 32'(open_cur)) begin
          done_next   = 1'b1;
          status_next = ST_BAD;
          state_next  = S_IDLE;
        end else begin
          heap_next  = hidx32[HIW-1:0];
          pidx_next  = pidx32[JW-1:0];
          mem_raddr  = row_base + AW'(hidx32[HIW-1:0]);
          state_next = S_FREE_WB;
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata | (WORDW'(1) << first_free);
          done_next   = 1'b1;
          baddr_next  = ((32'(heap) << info_q.per_shift) | 32'(first_free))
                        << info_q.blk_shift;
          bbytes_next = blk_bytes;
          state_next  = S_IDLE;
        end else if (32'(heap) + 32'd1 < 32'(open_cur)) begin
          heap_next = heap + HIW'(1);
          mem_raddr = row_base + AW'(heap) + AW'(1);
        end else if (32'(open_cur) < 32'(HEAPS)) begin
          open_we     = 1'b1;
          open_wval   = open_cur + HW'(1);
          mem_we      = 1'b1;
          mem_waddr   = row_base + AW'(open_cur);
          mem_wdata   = WORDW'(1);
          done_next   = 1'b1;
          baddr_next  = (32'(open_cur) << info_q.per_shift) << info_q.blk_shift;
          bbytes_next = blk_bytes;
          state_next  = S_IDLE;
        end else begin
          done_next   = 1'b1;
          status_next = ST_FULL;
          state_next  = S_IDLE;
        end
      end
      S_FREE_WB: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata & ~(WORDW'(1) << pidx);
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      for (int o = 0; o <= MAX_ORDER; o++) begin
        heaps_open[o] <= HW'(1);
      end
    end else begin
      state   <= state_next;
      clr_cnt <= clr_next;
      done    <= done_next;
      if (open_we) begin
        heaps_open[ord] <= open_wval;
      end
    end
    if (state == S_IDLE && start) begin
      act_q  <= action;
      addr_q <= free_addr;
      info_q <= info_in;
    end
    heap        <= heap_next;
    pidx        <= pidx_next;
    status      <= status_next;
    block_addr  <= baddr_next;
    block_bytes <= bbytes_next;
  end

`ifndef NO_ASSERTIONS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result for one request");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (block_addr == 32'd0 && block_bytes == 32'd0))
    else $error("error result carries a nonzero address or size");
`endif

endmodule
